@@ rtl/kpvf_pkg.sv @@
// Package: shared types, opcodes and fixed-point helpers for the position/velocity Kalman filter.
`timescale 1ns / 1ps
package kpvf_pkg;

	localparam int WORD_W = 64;
	localparam int CFG_W  = 51;
	localparam int STEP_W = 41;
	localparam int PORT_W = 32;

	localparam logic [1:0] REG_STEP_TIME   = 2'd0;
	localparam logic [1:0] REG_ACCEL_NOISE = 2'd1;
	localparam logic [1:0] REG_GPS_NOISE   = 2'd2;

	localparam logic ACT_PREDICT = 1'b0;
	localparam logic ACT_CORRECT = 1'b1;

	// ALU operations
	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_ADD,
		OP_SUB
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

	localparam logic signed [WORD_W-1:0] S64_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] S64_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	function automatic logic [WORD_W-1:0] magn(input logic signed [WORD_W-1:0] x);
		magn = x[WORD_W-1] ? (~x + 64'd1) : x;
	endfunction

	// sign + magnitude back to saturated signed
	function automatic logic signed [WORD_W-1:0] from_sm(input logic neg,
			input logic [WORD_W:0] m);
		logic signed [WORD_W-1:0] r;
		begin
			if (neg) begin
				if (m >= {1'b0, 1'b1, {(WORD_W-1){1'b0}}})
					r = S64_MIN;
				else
					r = ~m[WORD_W-1:0] + 64'd1;
			end else begin
				if (m > {2'b00, {(WORD_W-1){1'b1}}})
					r = S64_MAX;
				else
					r = m[WORD_W-1:0];
			end
			from_sm = r;
		end
	endfunction

endpackage

@@ rtl/kalman_position_velocity_filter.sv @@
// Top level: register file, state, and the sequencer driving the shared ALU.
// Operations: predict is 27 ALU ops (15 multiplies, 12 adds); correct is 15 ops
// (two 128-step divides, 6 multiplies, 7 adds/subs).
// Throughput: one transaction at a time; the next is accepted in the cycle after the
// result is loaded, and the load waits while the result register is still stalled.
// Reset: state zero, covariance identity, registers at their defaults.
`timescale 1ns / 1ps
module kalman_position_velocity_filter #(
	parameter int INTERNAL_FRAC_BITS = 40,
	parameter int PORT_FRAC_BITS     = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [kpvf_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic signed [kpvf_pkg::PORT_W-1:0] sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [kpvf_pkg::PORT_W-1:0] position,
	output logic signed [kpvf_pkg::PORT_W-1:0] velocity
);
	import kpvf_pkg::*;

	localparam int SH = INTERNAL_FRAC_BITS - PORT_FRAC_BITS;
	localparam logic signed [WORD_W-1:0] FX_ONE  = WORD_W'(1) << INTERNAL_FRAC_BITS;
	localparam logic signed [WORD_W-1:0] FX_HALF = WORD_W'(1) << (INTERNAL_FRAC_BITS - 1);
	localparam logic signed [WORD_W-1:0] FX_QTR  = WORD_W'(1) << (INTERNAL_FRAC_BITS - 2);

	// operand sources
	typedef enum logic [4:0] {
		R_PE, R_VE, R_PP, R_PV, R_VP, R_VV, R_Z, R_DT, R_Q, R_RN,
		R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_ONE, R_HALF, R_QTR
	} src_t;

	typedef struct packed {
		alu_op_t op;
		src_t    sa;
		src_t    sb;
		src_t    dst;
		logic    last;
	} uop_t;

	localparam int NUOP = 42;
	localparam int PC_W = $clog2(NUOP);

	function automatic uop_t mk(input alu_op_t o, input src_t x, input src_t y,
			input src_t d, input logic l);
		mk = '{op: o, sa: x, sb: y, dst: d, last: l};
	endfunction

	// microprogram: predict at 0, correct at CORR_PC
	localparam logic [PC_W-1:0] CORR_PC = PC_W'(22);
	function automatic uop_t rom(input logic [PC_W-1:0] pc);
		uop_t u;
		begin
			case (pc)
				// dt2=T0
				6'd0:  u = mk(OP_MUL, R_DT, R_DT, R_T0, 1'b0);
				// q00 -> T1
				6'd1:  u = mk(OP_MUL, R_QTR, R_T0, R_T1, 1'b0);
				6'd2:  u = mk(OP_MUL, R_T1, R_T0, R_T1, 1'b0);
				6'd3:  u = mk(OP_MUL, R_T1, R_Q, R_T1, 1'b0);
				// q01 -> T2
				6'd4:  u = mk(OP_MUL, R_HALF, R_T0, R_T2, 1'b0);
				6'd5:  u = mk(OP_MUL, R_T2, R_DT, R_T2, 1'b0);
				6'd6:  u = mk(OP_MUL, R_T2, R_Q, R_T2, 1'b0);
				// position and velocity
				6'd7:  u = mk(OP_MUL, R_VE, R_DT, R_T3, 1'b0);
				6'd8:  u = mk(OP_ADD, R_PE, R_T3, R_PE, 1'b0);
				6'd9:  u = mk(OP_MUL, R_HALF, R_Z, R_T3, 1'b0);
				6'd10: u = mk(OP_MUL, R_T3, R_T0, R_T3, 1'b0);
				6'd11: u = mk(OP_ADD, R_PE, R_T3, R_PE, 1'b0);
				6'd12: u = mk(OP_MUL, R_Z, R_DT, R_T3, 1'b0);
				6'd13: u = mk(OP_ADD, R_VE, R_T3, R_VE, 1'b0);
				// npp -> T4
				6'd14: u = mk(OP_ADD, R_VP, R_PV, R_T3, 1'b0);
				6'd15: u = mk(OP_MUL, R_DT, R_T3, R_T3, 1'b0);
				6'd16: u = mk(OP_ADD, R_PP, R_T3, R_T4, 1'b0);
				6'd17: u = mk(OP_MUL, R_T0, R_VV, R_T3, 1'b0);
				6'd18: u = mk(OP_ADD, R_T4, R_T3, R_T4, 1'b0);
				6'd19: u = mk(OP_ADD, R_T4, R_T1, R_PP, 1'b0);
				6'd20: u = mk(OP_MUL, R_DT, R_VV, R_T3, 1'b0);
				6'd21: u = mk(OP_ADD, R_PV, R_T3, R_PV, 1'b0);
				// correct: y=T0 s=T1 k0=T2 k1=T3 omk=T4
				6'd22: u = mk(OP_SUB, R_Z, R_PE, R_T0, 1'b0);
				6'd23: u = mk(OP_ADD, R_PP, R_RN, R_T1, 1'b0);
				6'd24: u = mk(OP_DIV, R_PP, R_T1, R_T2, 1'b0);
				6'd25: u = mk(OP_DIV, R_VP, R_T1, R_T3, 1'b0);
				6'd26: u = mk(OP_SUB, R_ONE, R_T2, R_T4, 1'b0);
				6'd27: u = mk(OP_MUL, R_T2, R_T0, R_T5, 1'b0);
				6'd28: u = mk(OP_ADD, R_PE, R_T5, R_PE, 1'b0);
				6'd29: u = mk(OP_MUL, R_T3, R_T0, R_T5, 1'b0);
				6'd30: u = mk(OP_ADD, R_VE, R_T5, R_VE, 1'b0);
				6'd31: u = mk(OP_MUL, R_T3, R_PP, R_T5, 1'b0);
				6'd32: u = mk(OP_SUB, R_VP, R_T5, R_VP, 1'b0);
				6'd33: u = mk(OP_MUL, R_T3, R_PV, R_T5, 1'b0);
				6'd34: u = mk(OP_SUB, R_VV, R_T5, R_VV, 1'b0);
				6'd35: u = mk(OP_MUL, R_T4, R_PP, R_PP, 1'b0);
				6'd36: u = mk(OP_MUL, R_T4, R_PV, R_PV, 1'b1);
				// predict tail
				6'd37: u = mk(OP_ADD, R_PV, R_T2, R_PV, 1'b0);
				6'd38: u = mk(OP_ADD, R_VP, R_T3, R_VP, 1'b0);
				6'd39: u = mk(OP_ADD, R_VP, R_T2, R_VP, 1'b0);
				// q11 -> T5
				6'd40: u = mk(OP_MUL, R_T0, R_Q, R_T5, 1'b0);
				default: u = mk(OP_ADD, R_VV, R_T5, R_VV, 1'b1);
			endcase
			rom = u;
		end
	endfunction

	// predict order 0..21, then 37..41 (T3 in 38 = dt*vv from step 20)
	function automatic logic [PC_W-1:0] next_pc(input logic [PC_W-1:0] pc);
		if (pc == PC_W'(21))
			next_pc = PC_W'(37);
		else
			next_pc = pc + 1'b1;
	endfunction

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_OUT
	} seq_t;

	seq_t                     st_q;
	logic [PC_W-1:0]          pc_q;
	logic [STEP_W-1:0]        dt_q;
	logic [CFG_W-1:0]         qn_q, rn_q;
	logic signed [WORD_W-1:0] reg_q [19];
	logic signed [WORD_W-1:0] z_in;
	logic [WORD_W-1:0]        zm;
	uop_t                     u;
	alu_ctl_t                 ctl;
	logic                     alu_done;
	logic signed [WORD_W-1:0] alu_res, opa, opb;

	assign u = rom(pc_q);

	always_comb begin
		opa = reg_q[u.sa];
		opb = reg_q[u.sb];
		case (u.sa)
			R_DT:    opa = {{(WORD_W-STEP_W){1'b0}}, dt_q};
			R_Q:     opa = {{(WORD_W-CFG_W){1'b0}}, qn_q};
			R_ONE:   opa = FX_ONE;
			R_HALF:  opa = FX_HALF;
			R_QTR:   opa = FX_QTR;
			default: ;
		endcase
		case (u.sb)
			R_DT:    opb = {{(WORD_W-STEP_W){1'b0}}, dt_q};
			R_Q:     opb = {{(WORD_W-CFG_W){1'b0}}, qn_q};
			R_RN:    opb = {{(WORD_W-CFG_W){1'b0}}, rn_q};
			default: ;
		endcase
	end

	assign ctl = '{start: (st_q == S_ISSUE), op: u.op};

	kpvf_alu #(.FRAC(INTERNAL_FRAC_BITS)) u_alu (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .a(opa), .b(opb),
		.done(alu_done), .result(alu_res));

	// port input conversion with saturation
	always_comb begin
		zm = magn(WORD_W'(sample));
		if ((zm >> (WORD_W - 1 - SH)) != '0)
			z_in = from_sm(sample[PORT_W-1], {1'b0, {WORD_W{1'b1}}});
		else
			z_in = from_sm(sample[PORT_W-1], {1'b0, zm << SH});
	end

	function automatic logic signed [PORT_W-1:0] port_out(input logic signed [WORD_W-1:0] x);
		logic [WORD_W:0] m;
		begin
			m = {1'b0, magn(x)};
			m = (m + ((WORD_W+1)'(1) << (SH - 1))) >> SH;
			if (!x[WORD_W-1] && m > (WORD_W+1)'(32'h7FFF_FFFF))
				m = (WORD_W+1)'(32'h7FFF_FFFF);
			if (x[WORD_W-1] && m > (WORD_W+1)'(32'h8000_0000))
				m = (WORD_W+1)'(32'h8000_0000);
			port_out = x[WORD_W-1] ? PORT_W'(~m + 1'b1) : PORT_W'(m);
		end
	endfunction

	assign in_stall = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			pc_q      <= '0;
			out_valid <= 1'b0;
			position  <= '0;
			velocity  <= '0;
			dt_q      <= STEP_W'(64'd4398046511);
			qn_q      <= CFG_W'(64'd1) << 40;
			rn_q      <= CFG_W'(64'd1) << 40;
			for (int i = 0; i < 19; i++)
				reg_q[i] <= '0;
			reg_q[R_PP] <= FX_ONE;
			reg_q[R_VV] <= FX_ONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_TIME:   dt_q <= cfg_data[STEP_W-1:0];
					REG_ACCEL_NOISE: qn_q <= cfg_data;
					REG_GPS_NOISE:   rn_q <= cfg_data;
					default: ;
				endcase
			end
			if (st_q == S_OUT && (!out_valid || !out_stall))
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						reg_q[R_Z] <= z_in;
						pc_q <= (action == ACT_CORRECT) ? CORR_PC : '0;
						st_q <= S_ISSUE;
					end
				end
				S_ISSUE: st_q <= S_WAIT;
				S_WAIT: begin
					if (alu_done) begin
						reg_q[u.dst] <= alu_res;
						if (u.last)
							st_q <= S_OUT;
						else begin
							pc_q <= next_pc(pc_q);
							st_q <= S_ISSUE;
						end
					end
				end
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						position  <= port_out(reg_q[R_PE]);
						velocity  <= port_out(reg_q[R_VE]);
						st_q      <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> st_q == S_ISSUE)
		else $error("transaction not started");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_ISSUE |=> st_q == S_WAIT)
		else $error("issue without wait");

endmodule

@@ rtl/kpvf_alu.sv @@
// Shared arithmetic unit: serial multiply, restoring divide, saturating add/sub.
`timescale 1ns / 1ps
module kpvf_alu #(
	parameter int FRAC = 40
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kpvf_pkg::alu_ctl_t            ctl,
	input  logic signed [kpvf_pkg::WORD_W-1:0] a,
	input  logic signed [kpvf_pkg::WORD_W-1:0] b,
	output logic                          done,
	output logic signed [kpvf_pkg::WORD_W-1:0] result
);
	import kpvf_pkg::*;

	localparam int DIV_STEPS = 2 * WORD_W;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} st_t;

	st_t                 st_q;
	alu_op_t             op_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic [WORD_W-1:0]   ma_q;
	logic [WORD_W-1:0]   mb_q;
	logic [2*WORD_W-1:0] acc_q;
	logic [WORD_W:0]     rem_q;
	logic [2*WORD_W-1:0] num_q;
	logic                dz_q;

	// multiply: 4 partial products of 32x32, one per cycle
	logic [1:0]          mi;
	logic [31:0]         pa, pb;
	logic [63:0]         pp;
	logic [2*WORD_W-1:0] pp_sh;
	logic [WORD_W:0]     rem_sh;
	logic [WORD_W:0]     rem_sub;
	logic [2*WORD_W-1:0] rnd;
	logic [WORD_W:0]     mul_m;
	logic [WORD_W:0]     div_m;
	logic signed [WORD_W-1:0] add_r, sub_r;
	logic signed [WORD_W-1:0] sum_a, sum_b, diff;

	assign mi    = cnt_q[1:0];
	assign pa    = mi[0] ? ma_q[63:32] : ma_q[31:0];
	assign pb    = mi[1] ? mb_q[63:32] : mb_q[31:0];
	assign pp    = pa * pb;
	assign pp_sh = {64'd0, pp} << ({6'd0, mi[0]} * 7'd32 + {6'd0, mi[1]} * 7'd32);

	assign rem_sh  = {rem_q[WORD_W-1:0], num_q[2*WORD_W-1]};
	assign rem_sub = rem_sh - {1'b0, mb_q};

	assign rnd   = acc_q + ({{(2*WORD_W-1){1'b0}}, 1'b1} << (FRAC - 1));
	assign mul_m = ((rnd >> FRAC) >> WORD_W) != '0 ? {1'b0, {WORD_W{1'b1}}}
		: {1'b0, rnd[FRAC +: WORD_W]};
	assign div_m = dz_q ? '0 : (acc_q[2*WORD_W-1:WORD_W] != '0 ? {1'b0, {WORD_W{1'b1}}}
		: {1'b0, acc_q[WORD_W-1:0]});

	assign sum_a = a + b;
	assign diff  = a - b;
	assign sum_b = '0;
	always_comb begin
		add_r = sum_a;
		if (a[WORD_W-1] == b[WORD_W-1] && sum_a[WORD_W-1] != a[WORD_W-1])
			add_r = a[WORD_W-1] ? S64_MIN : S64_MAX;
		sub_r = diff;
		if (a[WORD_W-1] != b[WORD_W-1] && diff[WORD_W-1] != a[WORD_W-1])
			sub_r = a[WORD_W-1] ? S64_MIN : S64_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			done   <= 1'b0;
			op_q   <= OP_ADD;
			cnt_q  <= '0;
			result <= sum_b;
		end else begin
			done <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (ctl.start) begin
						op_q  <= ctl.op;
						neg_q <= a[WORD_W-1] ^ b[WORD_W-1];
						ma_q  <= magn(a);
						mb_q  <= magn(b);
						acc_q <= '0;
						rem_q <= '0;
						num_q <= {{(WORD_W-FRAC){1'b0}}, magn(a), {FRAC{1'b0}}};
						dz_q  <= (b == '0);
						cnt_q <= '0;
						case (ctl.op)
							OP_MUL: st_q <= ST_MUL;
							OP_DIV: st_q <= ST_DIV;
							OP_ADD: begin
								result <= add_r;
								done   <= 1'b1;
							end
							default: begin
								result <= sub_r;
								done   <= 1'b1;
							end
						endcase
					end
				end
				ST_MUL: begin
					acc_q <= acc_q + pp_sh;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(3))
						st_q <= ST_FIN;
				end
				ST_DIV: begin
					// quotient bits shift into acc_q
					num_q <= num_q << 1;
					if (rem_q[WORD_W-1] || rem_sh >= {1'b0, mb_q}) begin
						rem_q <= rem_sub;
						acc_q <= {acc_q[2*WORD_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						acc_q <= {acc_q[2*WORD_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						st_q <= ST_FIN;
				end
				ST_FIN: begin
					result <= (op_q == OP_MUL) ? from_sm(neg_q, mul_m)
						: (dz_q ? sum_b : from_sm(neg_q, div_m));
					done <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start && (ctl.op == OP_MUL || ctl.op == OP_DIV) |=> !done)
		else $error("long op finished early");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIN |=> done)
		else $error("finish without done");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> cnt_q <= CNT_W'(DIV_STEPS - 1))
		else $error("divide count overrun");

endmodule
